FILE: src/assert_macros.svh
// Assertion macros for the RTL files; the top-level unit includes them.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Check a property on every rising clock edge while reset is released.
`define CPP_ASSERT(lbl, clk, rst_n, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Check a property on every rising clock edge, reset included.
`define CPP_ASSERT_ALWAYS(lbl, clk, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

FILE: src/cpp_pkg.sv
// ---------------------------------------------------------------------------
// cpp_pkg: shared definitions of the closest point on polyline unit
// Constants, command and status types between controller and datapath.
// ---------------------------------------------------------------------------
package cpp_pkg;

  localparam int COORD_WIDTH_DEF = 32;
  // Fraction bits of the coordinates; the arithmetic does not depend on it,
  // only the meaning of the numbers does.
  localparam int FRAC_BITS = 16;
  // Fraction bits of the segment parameter t.
  localparam int T_BITS = 32;
  // Width of the reported squared distance.
  localparam int DIST_W = 63;

  typedef enum logic [3:0] {
    OP_NONE,
    OP_LOAD,
    OP_MUL_ND,
    OP_ACC_ND,
    OP_DIV_INIT,
    OP_DIV_STEP,
    OP_PMUL,
    OP_PACC,
    OP_DMUL,
    OP_DACC,
    OP_COMMIT,
    OP_EMIT
  } op_t;

  typedef struct packed {
    logic       in_ready;
    op_t        op;
    logic [2:0] idx;
  } cmd_t;

  typedef struct packed {
    logic first;
    logic last;
    logic div_long;
    logic out_free;
  } status_t;

endpackage

FILE: src/cpp_in_if.sv
// ---------------------------------------------------------------------------
// cpp_in_if: vertex input channel
// Valid/ready channel carrying one polyline vertex and the query point.
// ---------------------------------------------------------------------------
interface cpp_in_if #(
  parameter int COORD_WIDTH = cpp_pkg::COORD_WIDTH_DEF
);
  logic                          valid;
  logic                          ready;
  logic                          first;
  logic                          last;
  logic signed [COORD_WIDTH-1:0] vertex_x;
  logic signed [COORD_WIDTH-1:0] vertex_y;
  logic signed [COORD_WIDTH-1:0] vertex_z;
  logic signed [COORD_WIDTH-1:0] query_x;
  logic signed [COORD_WIDTH-1:0] query_y;
  logic signed [COORD_WIDTH-1:0] query_z;

  modport source (output valid, first, last, vertex_x, vertex_y, vertex_z,
                  query_x, query_y, query_z, input ready);
  modport sink (input valid, first, last, vertex_x, vertex_y, vertex_z,
                query_x, query_y, query_z, output ready);
endinterface

FILE: src/cpp_out_if.sv
// ---------------------------------------------------------------------------
// cpp_out_if: result channel
// Valid/ready channel carrying the closest point and its squared distance.
// ---------------------------------------------------------------------------
interface cpp_out_if #(
  parameter int COORD_WIDTH = cpp_pkg::COORD_WIDTH_DEF
);
  logic                          valid;
  logic                          ready;
  logic signed [COORD_WIDTH-1:0] near_x;
  logic signed [COORD_WIDTH-1:0] near_y;
  logic signed [COORD_WIDTH-1:0] near_z;
  logic [cpp_pkg::DIST_W-1:0]    dist_sq;

  modport source (output valid, near_x, near_y, near_z, dist_sq, input ready);
  modport sink (input valid, near_x, near_y, near_z, dist_sq, output ready);
endinterface

FILE: src/cpp_ctrl.sv
// ---------------------------------------------------------------------------
// cpp_ctrl: sequencer of the closest point unit
// Steps the datapath through products, division, projection and compare.
// ---------------------------------------------------------------------------
module cpp_ctrl (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             in_valid,
  input  cpp_pkg::status_t status,
  output cpp_pkg::cmd_t    cmd
);

  localparam int CW = $clog2(cpp_pkg::T_BITS + 1);

  typedef enum logic [3:0] {
    S_IDLE, S_BRANCH, S_MUL_ND, S_ACC_ND, S_DIV_INIT, S_DIV,
    S_PMUL, S_PACC, S_DMUL, S_DACC, S_COMMIT, S_EMIT
  } state_t;

  state_t        state_r, state_nxt;
  logic [2:0]    idx_r, idx_nxt;
  logic [CW-1:0] cnt_r, cnt_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      idx_r   <= '0;
      cnt_r   <= '0;
    end else begin
      state_r <= state_nxt;
      idx_r   <= idx_nxt;
      cnt_r   <= cnt_nxt;
    end
  end

  always_comb begin
    state_nxt    = state_r;
    idx_nxt      = idx_r;
    cnt_nxt      = cnt_r;
    cmd.in_ready = 1'b0;
    cmd.op       = cpp_pkg::OP_NONE;
    cmd.idx      = idx_r;
    case (state_r)
      S_IDLE: begin
        cmd.in_ready = 1'b1;
        idx_nxt      = '0;
        if (in_valid) begin
          cmd.op    = cpp_pkg::OP_LOAD;
          state_nxt = S_BRANCH;
        end
      end
      S_BRANCH: begin
        // The first vertex only needs its distance to the new query.
        state_nxt = status.first ? S_DMUL : S_MUL_ND;
      end
      S_MUL_ND: begin
        cmd.op    = cpp_pkg::OP_MUL_ND;
        state_nxt = S_ACC_ND;
      end
      S_ACC_ND: begin
        cmd.op = cpp_pkg::OP_ACC_ND;
        if (idx_r == 3'd5) begin
          idx_nxt   = '0;
          state_nxt = S_DIV_INIT;
        end else begin
          idx_nxt   = idx_r + 3'd1;
          state_nxt = S_MUL_ND;
        end
      end
      S_DIV_INIT: begin
        cmd.op    = cpp_pkg::OP_DIV_INIT;
        cnt_nxt   = '0;
        state_nxt = S_DIV;
      end
      S_DIV: begin
        if (!status.div_long) begin
          state_nxt = S_PMUL;
        end else begin
          cmd.op  = cpp_pkg::OP_DIV_STEP;
          cnt_nxt = cnt_r + CW'(1);
          if (cnt_r == CW'(cpp_pkg::T_BITS - 1)) begin
            state_nxt = S_PMUL;
          end
        end
      end
      S_PMUL: begin
        cmd.op    = cpp_pkg::OP_PMUL;
        state_nxt = S_PACC;
      end
      S_PACC: begin
        cmd.op = cpp_pkg::OP_PACC;
        if (idx_r == 3'd2) begin
          idx_nxt   = '0;
          state_nxt = S_DMUL;
        end else begin
          idx_nxt   = idx_r + 3'd1;
          state_nxt = S_PMUL;
        end
      end
      S_DMUL: begin
        cmd.op    = cpp_pkg::OP_DMUL;
        state_nxt = S_DACC;
      end
      S_DACC: begin
        cmd.op = cpp_pkg::OP_DACC;
        if (idx_r == 3'd2) begin
          idx_nxt   = '0;
          state_nxt = S_COMMIT;
        end else begin
          idx_nxt   = idx_r + 3'd1;
          state_nxt = S_DMUL;
        end
      end
      S_COMMIT: begin
        cmd.op    = cpp_pkg::OP_COMMIT;
        state_nxt = status.last ? S_EMIT : S_IDLE;
      end
      S_EMIT: begin
        if (status.out_free) begin
          cmd.op    = cpp_pkg::OP_EMIT;
          state_nxt = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

endmodule

FILE: src/cpp_dp.sv
// ---------------------------------------------------------------------------
// cpp_dp: datapath of the closest point unit
// Shared multiplier, accumulators, restoring divider and point registers.
// ---------------------------------------------------------------------------
module cpp_dp #(
  parameter int COORD_WIDTH = cpp_pkg::COORD_WIDTH_DEF
) (
  input  logic             clk,
  input  logic             rst_n,
  input  cpp_pkg::cmd_t    cmd,
  output cpp_pkg::status_t status,
  cpp_in_if.sink           in_ch,
  cpp_out_if.source        out_ch
);

  localparam int W  = COORD_WIDTH;
  localparam int T  = cpp_pkg::T_BITS;
  localparam int TW = T + 1;
  localparam int MW = (W + 2 > T + 1) ? W + 2 : T + 1;
  localparam int PW = 2 * MW;
  localparam int NW = 2 * W + 3;
  localparam int DW = 2 * W + 2;
  localparam int SW = cpp_pkg::DIST_W;

  logic signed [W-1:0] q_r[3], prev_r[3], best_r[3], v_r[3], c_r[3];
  logic [DW-1:0]       best_dist_r, den_r, acc_r;
  logic signed [NW-1:0] num_r;
  logic [NW-1:0]       rem_r;
  logic [TW-1:0]       t_r;
  logic [PW-1:0]       p_r;
  logic                psign_r, first_r, last_r, div_long_r, out_valid_r;
  logic signed [W-1:0] near_r[3];
  logic [SW-1:0]       dist_out_r;

  logic signed [W:0] d[3], w[3], e[3];
  logic [W:0]        dm[3], wm[3], em[3];
  logic [1:0]        lane;
  logic [MW-1:0]     opa, opb;
  logic              osign;
  logic [NW-1:0]     r2;
  logic [PW:0]       rsum;
  logic [W:0]        off;
  logic signed [W+1:0] cpos;
  logic [DW+SW-1:0]  dext;

  for (genvar i = 0; i < 3; i++) begin : g_lane
    assign d[i]  = (W+1)'(v_r[i]) - (W+1)'(prev_r[i]);
    assign w[i]  = (W+1)'(q_r[i]) - (W+1)'(prev_r[i]);
    assign e[i]  = (W+1)'(q_r[i]) - (W+1)'(c_r[i]);
    assign dm[i] = d[i][W] ? (W+1)'(-d[i]) : d[i];
    assign wm[i] = w[i][W] ? (W+1)'(-w[i]) : w[i];
    assign em[i] = e[i][W] ? (W+1)'(-e[i]) : e[i];
  end

  // Numerator terms use idx 0..2, denominator terms idx 3..5; both map to lanes 0..2.
  assign lane = (cmd.idx >= 3'd3) ? 2'(cmd.idx - 3'd3) : cmd.idx[1:0];

  always_comb begin
    opa   = MW'(dm[lane]);
    opb   = MW'(dm[lane]);
    osign = 1'b0;
    case (cmd.op)
      cpp_pkg::OP_MUL_ND: begin
        if (cmd.idx < 3'd3) begin
          opa   = MW'(wm[lane]);
          osign = w[lane][W] ^ d[lane][W];
        end
      end
      cpp_pkg::OP_PMUL: opb = MW'(t_r);
      cpp_pkg::OP_DMUL: begin
        opa = MW'(em[lane]);
        opb = MW'(em[lane]);
      end
      default: ;
    endcase
  end

  assign r2   = {rem_r[NW-2:0], 1'b0};
  // Round half away from zero on the magnitude, then apply the sign.
  assign rsum = (PW+1)'(p_r) + ((PW+1)'(1) << (T - 1));
  assign off  = rsum[T+W:T];
  assign cpos = d[lane][W] ? (W+2)'(prev_r[lane]) - (W+2)'(off)
                           : (W+2)'(prev_r[lane]) + (W+2)'(off);
  assign dext = (DW+SW)'(best_dist_r);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < 3; i++) begin
        q_r[i]    <= '0;
        prev_r[i] <= '0;
        best_r[i] <= '0;
      end
      best_dist_r <= '1;
      out_valid_r <= 1'b0;
      first_r     <= 1'b0;
      last_r      <= 1'b0;
      div_long_r  <= 1'b0;
    end else begin
      if (cmd.op == cpp_pkg::OP_EMIT) begin
        out_valid_r <= 1'b1;
      end else if (out_valid_r && out_ch.ready) begin
        out_valid_r <= 1'b0;
      end
      case (cmd.op)
        cpp_pkg::OP_LOAD: begin
          v_r[0]  <= in_ch.vertex_x;
          v_r[1]  <= in_ch.vertex_y;
          v_r[2]  <= in_ch.vertex_z;
          first_r <= in_ch.first;
          last_r  <= in_ch.last;
          num_r   <= '0;
          den_r   <= '0;
          acc_r   <= '0;
          if (in_ch.first) begin
            q_r[0] <= in_ch.query_x;
            q_r[1] <= in_ch.query_y;
            q_r[2] <= in_ch.query_z;
            c_r[0] <= in_ch.vertex_x;
            c_r[1] <= in_ch.vertex_y;
            c_r[2] <= in_ch.vertex_z;
          end
        end
        cpp_pkg::OP_MUL_ND, cpp_pkg::OP_PMUL, cpp_pkg::OP_DMUL: begin
          p_r     <= opa * opb;
          psign_r <= osign;
        end
        cpp_pkg::OP_ACC_ND: begin
          if (cmd.idx < 3'd3) begin
            num_r <= psign_r ? num_r - $signed(NW'(p_r)) : num_r + $signed(NW'(p_r));
          end else begin
            den_r <= den_r + DW'(p_r);
          end
        end
        cpp_pkg::OP_DIV_INIT: begin
          rem_r <= num_r;
          if (den_r == '0 || num_r[NW-1] || num_r == '0) begin
            t_r        <= '0;
            div_long_r <= 1'b0;
          end else if (num_r >= $signed(NW'(den_r))) begin
            t_r        <= TW'(1) << T;
            div_long_r <= 1'b0;
          end else begin
            t_r        <= '0;
            div_long_r <= 1'b1;
          end
        end
        cpp_pkg::OP_DIV_STEP: begin
          if (r2 >= NW'(den_r)) begin
            rem_r <= r2 - NW'(den_r);
            t_r   <= {t_r[TW-2:0], 1'b1};
          end else begin
            rem_r <= r2;
            t_r   <= {t_r[TW-2:0], 1'b0};
          end
        end
        cpp_pkg::OP_PACC: c_r[lane] <= cpos[W-1:0];
        cpp_pkg::OP_DACC: acc_r <= acc_r + DW'(p_r);
        cpp_pkg::OP_COMMIT: begin
          // Strict compare keeps the earlier point on a tie.
          if (first_r || acc_r < best_dist_r) begin
            best_r      <= c_r;
            best_dist_r <= acc_r;
          end
          prev_r <= v_r;
        end
        cpp_pkg::OP_EMIT: begin
          near_r     <= best_r;
          dist_out_r <= (|dext[DW+SW-1:SW]) ? '1 : dext[SW-1:0];
        end
        default: ;
      endcase
    end
  end

  assign status.first    = first_r;
  assign status.last     = last_r;
  assign status.div_long = div_long_r;
  assign status.out_free = !out_valid_r || out_ch.ready;

  assign in_ch.ready    = cmd.in_ready;
  assign out_ch.valid   = out_valid_r;
  assign out_ch.near_x  = near_r[0];
  assign out_ch.near_y  = near_r[1];
  assign out_ch.near_z  = near_r[2];
  assign out_ch.dist_sq = dist_out_r;

endmodule

FILE: src/closest_point_on_polyline_unit.sv
// ---------------------------------------------------------------------------
// closest_point_on_polyline_unit: nearest point of a query on a 3D polyline
// Takes polyline vertices one per transfer and reports the nearest point.
// ---------------------------------------------------------------------------
//
//   channel  direction  payload
//   in_ch    input      first, last, vertex_x/y/z, query_x/y/z
//   out_ch   output     near_x/y/z, dist_sq (one transfer after each last)
//
// An item with its first flag set goes from its transfer straight to the
// distance to its query. Any other item first forms the dot products of
// its segment and, unless its segment parameter lands on an end, runs the
// 32-step restoring divider that finds the segment parameter. A last item
// also moves its result into the output register once that is free.
// One item is worked on at a time; in_ch.ready is high only while waiting.
// Reset is synchronous and active low; it clears the latched query, the
// previous vertex and the best point, and sets the best distance to its
// maximum. A result waits in the output register while the next item runs;
// the unit stalls only if a second result finds that register still full.
//
`include "assert_macros.svh"

module closest_point_on_polyline_unit #(
  parameter int COORD_WIDTH = cpp_pkg::COORD_WIDTH_DEF
) (
  input logic       clk,
  input logic       rst_n,
  cpp_in_if.sink    in_ch,
  cpp_out_if.source out_ch
);

  cpp_pkg::cmd_t    cmd;
  cpp_pkg::status_t status;

  // The controller sequences the work of one vertex: the dot products of
  // the segment, the division for its parameter, the projection, the
  // distance to the query and the compare against the best point.
  cpp_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_ch.valid),
    .status   (status),
    .cmd      (cmd)
  );

  // The datapath owns the data and point registers and the single shared multiplier.
  cpp_dp #(
    .COORD_WIDTH (COORD_WIDTH)
  ) u_dp (
    .clk    (clk),
    .rst_n  (rst_n),
    .cmd    (cmd),
    .status (status),
    .in_ch  (in_ch),
    .out_ch (out_ch)
  );

  // Only one item is in flight: after a transfer in, the input stays closed.
  `CPP_ASSERT(a_one_item, clk, rst_n, (in_ch.valid && in_ch.ready) |=> !in_ch.ready, "input reopened while busy")

  // Division steps are issued only for a parameter strictly inside (0,1).
  `CPP_ASSERT(a_div_long, clk, rst_n, (cmd.op == cpp_pkg::OP_DIV_STEP) |-> status.div_long, "divider stepped on a trivial case")

  // A result is only written when the output register can take it.
  `CPP_ASSERT(a_emit_free, clk, rst_n, (cmd.op == cpp_pkg::OP_EMIT) |-> status.out_free, "result overwrote a pending transfer")

endmodule

FILE: verif/tb_closest_point_on_polyline_unit.sv
`timescale 1ns / 100ps
// ---------------------------------------------------------------------------
// tb_closest_point_on_polyline_unit: self-checking bench of the polyline unit
// Streams directed and random polylines into the unit, predicts the nearest
// point and squared distance of every polyline, and compares each result.
// ---------------------------------------------------------------------------
module tb_closest_point_on_polyline_unit;

  localparam int CW          = cpp_pkg::COORD_WIDTH_DEF;
  localparam int N_RANDOM    = 2000;
  localparam int STALL_LIMIT = 4000;
  localparam logic [127:0] DIST_CAP = (128'd1 << cpp_pkg::DIST_W) - 128'd1;

  typedef struct {
    logic          first;
    logic          last;
    logic [CW-1:0] vtx[3];
    logic [CW-1:0] qry[3];
  } vertex_item_t;

  typedef struct {
    logic [CW-1:0]              near_pt[3];
    logic [cpp_pkg::DIST_W-1:0] dist_val;
  } nearest_t;

  logic clk;
  logic rst_n;

  cpp_in_if  #(.COORD_WIDTH(CW)) in_ch ();
  cpp_out_if #(.COORD_WIDTH(CW)) out_ch ();

  closest_point_on_polyline_unit #(.COORD_WIDTH(CW)) u_dut (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_ch),
    .out_ch (out_ch)
  );

  // The clock runs at a 4 ns period.
  always begin
    clk = 1'b1;
    #2;
    clk = 1'b0;
    #2;
  end

  // Vertices waiting to be driven, and nearest points waiting to come out.
  vertex_item_t vertex_q[$];
  nearest_t     nearest_q[$];

  // Predictor state: the copy of what the unit holds between vertices.
  longint       query_hold[3];
  longint       prev_vtx[3];
  longint       best_pt[3];
  logic [127:0] best_d;

  int  n_vertices;
  int  n_results;
  int  n_errors;
  logic in_taken;
  logic no_idle;

  // Exact squared distance between two points; differences fit in 33 bits.
  function automatic logic [127:0] sq_distance(longint p[3], longint q[3]);
    logic signed [127:0] diff;
    logic [127:0]        acc;
    acc = '0;
    for (int i = 0; i < 3; i++) begin
      diff = q[i] - p[i];
      acc += diff * diff;
    end
    return acc;
  endfunction

  // Projects the held query onto the segment from prev_vtx to b. The segment
  // parameter is truncated to T_BITS fraction bits and clamped to [0,1]; each
  // coordinate of the point is then rounded half away from zero.
  function automatic void project_query(longint b[3], output longint c[3]);
    longint              d[3];
    logic signed [127:0] wq;
    logic signed [127:0] wd;
    logic signed [127:0] num;
    logic signed [127:0] den;
    logic [127:0]        t;
    logic [127:0]        off;
    num = '0;
    den = '0;
    for (int i = 0; i < 3; i++) begin
      d[i] = b[i] - prev_vtx[i];
      wq   = query_hold[i] - prev_vtx[i];
      wd   = d[i];
      num += wq * wd;
      den += wd * wd;
    end
    if (den == 0 || num <= 0) begin
      t = '0;
    end else if (num >= den) begin
      t = 128'd1 << cpp_pkg::T_BITS;
    end else begin
      t = (128'(unsigned'(num)) << cpp_pkg::T_BITS) / 128'(unsigned'(den));
    end
    for (int i = 0; i < 3; i++) begin
      wd  = d[i];
      if (wd < 0) wd = -wd;
      off = (128'(unsigned'(wd)) * t + (128'd1 << (cpp_pkg::T_BITS - 1))) >> cpp_pkg::T_BITS;
      c[i] = (d[i] < 0) ? prev_vtx[i] - longint'(off) : prev_vtx[i] + longint'(off);
    end
  endfunction

  // Advances the predictor by one accepted vertex; returns 1 with the
  // expected nearest point when the vertex closes a polyline.
  function automatic bit nearest_step(vertex_item_t it, output nearest_t res);
    longint       v[3];
    longint       c[3];
    logic [127:0] dd;
    for (int i = 0; i < 3; i++) v[i] = longint'(signed'(it.vtx[i]));
    if (it.first) begin
      for (int i = 0; i < 3; i++) begin
        query_hold[i] = longint'(signed'(it.qry[i]));
        best_pt[i]    = v[i];
      end
      best_d = sq_distance(query_hold, v);
    end else begin
      project_query(v, c);
      dd = sq_distance(query_hold, c);
      // Strictly nearer only: a tie keeps the earlier point.
      if (dd < best_d) begin
        for (int i = 0; i < 3; i++) best_pt[i] = c[i];
        best_d = dd;
      end
    end
    for (int i = 0; i < 3; i++) prev_vtx[i] = v[i];
    for (int i = 0; i < 3; i++) res.near_pt[i] = best_pt[i][CW-1:0];
    res.dist_val = (best_d > DIST_CAP) ? DIST_CAP[cpp_pkg::DIST_W-1:0]
                                       : best_d[cpp_pkg::DIST_W-1:0];
    return it.last;
  endfunction

  function automatic logic [CW-1:0] pick_coord();
    case ($urandom_range(0, 9))
      0:       return {1'b0, {(CW-1){1'b1}}};
      1:       return {1'b1, {(CW-1){1'b0}}};
      2, 3, 4: return $urandom();
      default: return CW'($signed($urandom_range(0, 32'h0020_0000)) - 32'sh0010_0000);
    endcase
  endfunction

  // Queues one vertex; coordinates are given as integers in raw fixed point.
  task automatic push_vertex(logic f, logic l, longint vx, longint vy, longint vz,
                             longint qx = 0, longint qy = 0, longint qz = 0);
    vertex_item_t it;
    it.first  = f;
    it.last   = l;
    it.vtx[0] = vx[CW-1:0];
    it.vtx[1] = vy[CW-1:0];
    it.vtx[2] = vz[CW-1:0];
    it.qry[0] = qx[CW-1:0];
    it.qry[1] = qy[CW-1:0];
    it.qry[2] = qz[CW-1:0];
    vertex_q = {vertex_q, it};
  endtask

  // A well-formed polyline: first on the opening vertex, last on the closing
  // one. Half of them keep the query near the vertices so the projection
  // lands inside segments rather than being clamped.
  task automatic push_polyline();
    vertex_item_t it;
    int           len;
    bit           near_q;
    len    = $urandom_range(1, 8);
    near_q = $urandom_range(0, 1);
    for (int k = 0; k < len; k++) begin
      it.first = (k == 0);
      it.last  = (k == len - 1);
      for (int i = 0; i < 3; i++) begin
        it.vtx[i] = pick_coord();
        it.qry[i] = near_q ? it.vtx[i] + CW'($urandom_range(0, 4095)) - CW'(2048)
                           : pick_coord();
      end
      vertex_q = {vertex_q, it};
    end
  endtask

  // Noise: a vertex with random flags and random content, which may start,
  // end or continue whatever polyline is in progress.
  task automatic push_noise();
    vertex_item_t it;
    it.first = $urandom_range(0, 1);
    it.last  = $urandom_range(0, 1);
    for (int i = 0; i < 3; i++) begin
      it.vtx[i] = $urandom();
      it.qry[i] = $urandom();
    end
    vertex_q = {vertex_q, it};
  endtask

  // Driver: inputs change on the falling edge. A new vertex is loaded once
  // the previous one was transferred, unless this cycle is an idle one.
  always @(negedge clk) begin
    if (!rst_n) begin
      in_ch.valid <= 1'b0;
    end else if (!in_ch.valid || in_taken) begin
      if (vertex_q.size() > 0 && (no_idle || $urandom_range(0, 99) >= 30)) begin
        vertex_item_t it;
        it = vertex_q.pop_front();
        in_ch.valid    <= 1'b1;
        in_ch.first    <= it.first;
        in_ch.last     <= it.last;
        in_ch.vertex_x <= it.vtx[0];
        in_ch.vertex_y <= it.vtx[1];
        in_ch.vertex_z <= it.vtx[2];
        in_ch.query_x  <= it.qry[0];
        in_ch.query_y  <= it.qry[1];
        in_ch.query_z  <= it.qry[2];
      end else begin
        in_ch.valid <= 1'b0;
      end
    end
    // The receiver stalls at random too, apart from the quiet stretch.
    out_ch.ready <= rst_n && (no_idle || $urandom_range(0, 99) >= 30);
  end

  // Monitor: both channels are sampled on the rising edge. An accepted
  // vertex updates the predictor; an accepted result is checked against
  // the oldest expectation.
  always @(posedge clk) begin
    vertex_item_t it;
    nearest_t     exp_res;
    in_taken <= rst_n && in_ch.valid && in_ch.ready;
    if (rst_n && in_ch.valid && in_ch.ready) begin
      it.first  = in_ch.first;
      it.last   = in_ch.last;
      it.vtx[0] = in_ch.vertex_x;
      it.vtx[1] = in_ch.vertex_y;
      it.vtx[2] = in_ch.vertex_z;
      it.qry[0] = in_ch.query_x;
      it.qry[1] = in_ch.query_y;
      it.qry[2] = in_ch.query_z;
      n_vertices++;
      if (nearest_step(it, exp_res)) nearest_q = {nearest_q, exp_res};
    end
    if (rst_n && out_ch.valid && out_ch.ready) begin
      n_results++;
      if (nearest_q.size() == 0) begin
        n_errors++;
        $display("%0t: result with none expected: near %h %h %h dist %h", $realtime,
                 out_ch.near_x, out_ch.near_y, out_ch.near_z, out_ch.dist_sq);
      end else begin
        exp_res = nearest_q.pop_front();
        if (out_ch.near_x !== exp_res.near_pt[0]) begin
          n_errors++;
          $display("%0t: near_x expected %h actual %h", $realtime,
                   exp_res.near_pt[0], out_ch.near_x);
        end
        if (out_ch.near_y !== exp_res.near_pt[1]) begin
          n_errors++;
          $display("%0t: near_y expected %h actual %h", $realtime,
                   exp_res.near_pt[1], out_ch.near_y);
        end
        if (out_ch.near_z !== exp_res.near_pt[2]) begin
          n_errors++;
          $display("%0t: near_z expected %h actual %h", $realtime,
                   exp_res.near_pt[2], out_ch.near_z);
        end
        if (out_ch.dist_sq !== exp_res.dist_val) begin
          n_errors++;
          $display("%0t: dist_sq expected %h actual %h", $realtime,
                   exp_res.dist_val, out_ch.dist_sq);
        end
      end
    end
  end

  // Watchdog: while work is outstanding, count cycles without any transfer.
  int stall_cycles;
  always @(posedge clk) begin
    if (!rst_n || (in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready) ||
        (vertex_q.size() == 0 && !in_ch.valid && nearest_q.size() == 0)) begin
      stall_cycles <= 0;
    end else if (stall_cycles >= STALL_LIMIT) begin
      $display("closest_point_on_polyline_unit: mismatch");
      $finish;
    end else begin
      stall_cycles <= stall_cycles + 1;
    end
  end

  initial begin
    longint big;
    longint low;
    big = (64'sd1 <<< (CW - 1)) - 1;
    low = -(64'sd1 <<< (CW - 1));
    rst_n          = 1'b0;
    in_ch.valid    = 1'b0;
    in_ch.first    = 1'b0;
    in_ch.last     = 1'b0;
    in_ch.vertex_x = '0;
    in_ch.vertex_y = '0;
    in_ch.vertex_z = '0;
    in_ch.query_x  = '0;
    in_ch.query_y  = '0;
    in_ch.query_z  = '0;
    out_ch.ready   = 1'b0;
    in_taken       = 1'b0;
    no_idle        = 1'b0;
    stall_cycles   = 0;
    n_vertices     = 0;
    n_results      = 0;
    n_errors       = 0;
    for (int i = 0; i < 3; i++) begin
      query_hold[i] = 0;
      prev_vtx[i]   = 0;
      best_pt[i]    = 0;
    end
    best_d = '1;

    // Directed polylines. The first two vertices come before any first
    // flag, so segments start from the zeroed query and previous vertex.
    push_vertex(0, 0, 5 << 16, 5 << 16, 5 << 16);
    push_vertex(0, 1, -(3 << 16), 7 << 16, 1);
    // A lone vertex at the top of the range with the query at the bottom:
    // the distance overflows and must saturate.
    push_vertex(1, 1, big, big, big, low, low, low);
    // Zero-length segment: the repeated vertex projects onto its start.
    push_vertex(1, 0, 1000, -2000, 3000, 0, 0, 0);
    push_vertex(0, 1, 1000, -2000, 3000);
    // Tie: moving away clamps to the segment start at equal distance, so the
    // first point stays; then one segment projects inside and the last clamps to its start.
    push_vertex(1, 0, 2 << 16, 0, 0, 0, 0, 0);
    push_vertex(0, 0, 4 << 16, 0, 0);
    push_vertex(0, 0, 0, 2 << 16, 0);
    push_vertex(0, 1, 0, 9 << 16, 3);
    // A polyline restarted by a first in mid-stream.
    push_vertex(1, 0, low, 0, big, 77, -77, 1 << 20);
    push_vertex(0, 0, big, low, 0);
    push_vertex(1, 0, 300, 400, -500, 100, 100, 100);
    push_vertex(0, 1, -300, 400, 500);
    // Vertices after a last without a first continue the same polyline.
    push_vertex(0, 0, 123456, -654321, 42);
    push_vertex(0, 1, low, low, low);
    // Segments across the whole range with the query in the middle.
    push_vertex(1, 0, low, low, low, 1, -1, 0);
    push_vertex(0, 0, big, big, big);
    push_vertex(0, 1, low, big, low);

    repeat (11) @(posedge clk);
    rst_n <= 1'b1;

    // Hold back the random part until every directed result has arrived.
    do @(posedge clk);
    while (vertex_q.size() > 0 || in_ch.valid || nearest_q.size() > 0);

    while (vertex_q.size() + n_vertices < N_RANDOM + 18) begin
      if ($urandom_range(0, 99) < 85) push_polyline();
      else push_noise();
      // Feed the driver gradually and run a quiet stretch in the middle.
      while (vertex_q.size() > 32) @(posedge clk);
      no_idle = (n_vertices > 800 && n_vertices < 1100);
    end
    no_idle = 1'b0;

    do @(posedge clk);
    while (vertex_q.size() > 0 || in_ch.valid || nearest_q.size() > 0);
    repeat (200) @(posedge clk);

    $display("Ran %0d vertices through directed and random polylines; %0d results checked.",
             n_vertices, n_results);
    $display("Flagged %0d field mismatches or unexpected results.", n_errors);
    if (n_errors == 0 && nearest_q.size() == 0) begin
      $display("closest_point_on_polyline_unit: match");
    end else begin
      $display("closest_point_on_polyline_unit: mismatch");
    end
    $finish;
  end

endmodule
